@@ src/wpsg_pkg.sv @@
// Shared constants, types and table construction for the wheel phase sine/cosine generator.
`default_nettype none

package wpsg_pkg;

    localparam int TABLE_SEGMENTS = 16;
    localparam int PHASE_BITS     = 24;
    localparam int SEG_BITS       = $clog2(TABLE_SEGMENTS);
    localparam int FRAC_BITS      = PHASE_BITS - SEG_BITS;

    localparam int RATE_W    = 24;
    localparam int DIST_W    = 24;
    localparam int RATE_FRAC = 20;
    localparam int DIST_FRAC = 16;
    localparam int ADV_SHIFT = RATE_FRAC + DIST_FRAC - PHASE_BITS;
    localparam int ADV_W     = ADV_SHIFT + PHASE_BITS;

    localparam logic [RATE_W-1:0] RATE_RESET = RATE_W'(349525);

    localparam int OUT_W   = 16;
    localparam int OUT_ONE = 16384;

    // table points in Q2.30
    localparam int PT_W  = 32;
    localparam int DIF_W = PT_W + 1;
    localparam int MUL_W = 32;
    localparam int PRD_W = 2 * MUL_W;
    localparam int RND_W = PRD_W - PHASE_BITS;
    localparam int VAL_W = RND_W + 1;

    localparam int NORM_W = 32;
    localparam int Q_W    = 17;
    localparam int DIV_W  = NORM_W + 1 + Q_W - 1;
    localparam int CNT_W  = $clog2(Q_W);

    localparam int          TAYLOR_TERMS = 20;
    localparam longint unsigned ONE_Q30     = 64'd1 << 30;
    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

    typedef logic [TABLE_SEGMENTS:0][PT_W-1:0] t_pt_vec;

    typedef enum logic [2:0] {
        MS_ADV,
        MS_DCOS,
        MS_DSIN,
        MS_CSQ,
        MS_SSQ
    } t_mul_sel;

    typedef struct packed {
        logic     ld_in;
        t_mul_sel mul_sel;
        logic     upd_phase;
        logic     ld_pts;
        logic     ld_c;
        logic     ld_s;
        logic     ld_sq;
        logic     ld_norm;
        logic     div_init;
        logic     div_step;
        logic     ld_out;
    } t_cmd;

    // Shift-and-subtract long division, used only while the table is built.
    function automatic longint unsigned long_divide(input longint unsigned num,
                                                    input longint unsigned den);
        longint unsigned q;
        longint unsigned r;
        q = 0;
        r = 0;
        for (int b = 63; b >= 0; b--) begin
            r = (r << 1) | ((num >> b) & 64'd1);
            q = q << 1;
            if (r >= den) begin
                r = r - den;
                q = q | 64'd1;
            end
        end
        return q;
    endfunction

    // Points on the circle: quadrant symmetry plus a Taylor series in integers.
    function automatic t_pt_vec build_pts(input logic want_sin);
        t_pt_vec         v;
        longint unsigned q4;
        longint unsigned rem;
        longint unsigned x;
        longint unsigned t;
        longint          c;
        longint          s;
        longint          pc;
        longint          ps;
        int unsigned     quad;
        v = '0;
        for (int k = 0; k <= TABLE_SEGMENTS; k++) begin
            q4   = longint'(k) * 4;
            quad = int'((q4 / TABLE_SEGMENTS) & 3);
            rem  = q4 % TABLE_SEGMENTS;
            x    = (rem * HALF_PI_Q30 * 2 + TABLE_SEGMENTS) / (2 * TABLE_SEGMENTS);
            t    = ONE_Q30;
            c    = longint'(ONE_Q30);
            s    = 0;
            for (int j = 1; j <= TAYLOR_TERMS; j++) begin
                t = long_divide((t * x) >> 30, longint'(j));
                if ((j & 1) == 1) begin
                    s = ((((j - 1) >> 1) & 1) == 1) ? s - longint'(t) : s + longint'(t);
                end else begin
                    c = (((j >> 1) & 1) == 1) ? c - longint'(t) : c + longint'(t);
                end
            end
            unique case (quad)
                0: begin pc = c;  ps = s;  end
                1: begin pc = -s; ps = c;  end
                2: begin pc = -c; ps = -s; end
                default: begin pc = s; ps = -c; end
            endcase
            v[k] = want_sin ? PT_W'(ps) : PT_W'(pc);
        end
        return v;
    endfunction

    localparam t_pt_vec COS_PTS = build_pts(1'b0);
    localparam t_pt_vec SIN_PTS = build_pts(1'b1);

endpackage

`default_nettype wire

@@ src/wpsg_ctrl.sv @@
// Sequencer for the phase step, interpolation, renormalizing divide and output handshake.
`default_nettype none

module wpsg_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    output logic               o_ready,
    output logic               o_valid,
    input  wire logic          i_ready,
    output wpsg_pkg::t_cmd     o_cmd
);
    import wpsg_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_ADV,
        S_PHASE,
        S_LOOK,
        S_IC,
        S_IS,
        S_SC,
        S_SS,
        S_NORM,
        S_DIVI,
        S_DIV,
        S_DONE
    } t_state;

    t_state             r_state;
    logic [CNT_W-1:0]   r_cnt;
    logic               r_out_valid;
    t_cmd               w_cmd;

    assign o_ready = (r_state == S_IDLE);
    assign o_valid = r_out_valid;
    assign o_cmd   = w_cmd;

    always_comb begin
        w_cmd         = '0;
        w_cmd.mul_sel = MS_ADV;
        unique case (r_state)
            S_IDLE:  w_cmd.ld_in = i_valid;
            S_ADV:   w_cmd.mul_sel = MS_ADV;
            S_PHASE: w_cmd.upd_phase = 1'b1;
            S_LOOK:  w_cmd.ld_pts = 1'b1;
            S_IC:    w_cmd.mul_sel = MS_DCOS;
            S_IS: begin
                w_cmd.mul_sel = MS_DSIN;
                w_cmd.ld_c    = 1'b1;
            end
            S_SC: begin
                w_cmd.mul_sel = MS_CSQ;
                w_cmd.ld_s    = 1'b1;
            end
            S_SS: begin
                w_cmd.mul_sel = MS_SSQ;
                w_cmd.ld_sq   = 1'b1;
            end
            S_NORM:  w_cmd.ld_norm = 1'b1;
            S_DIVI:  w_cmd.div_init = 1'b1;
            S_DIV:   w_cmd.div_step = 1'b1;
            S_DONE:  w_cmd.ld_out = !r_out_valid || i_ready;
            default: w_cmd = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_cmd.ld_out) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE:  if (i_valid) r_state <= S_ADV;
                S_ADV:   r_state <= S_PHASE;
                S_PHASE: r_state <= S_LOOK;
                S_LOOK:  r_state <= S_IC;
                S_IC:    r_state <= S_IS;
                S_IS:    r_state <= S_SC;
                S_SC:    r_state <= S_SS;
                S_SS:    r_state <= S_NORM;
                S_NORM:  r_state <= S_DIVI;
                S_DIVI: begin
                    r_cnt   <= '0;
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == CNT_W'(Q_W - 1)) begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    // hold here while the previous word is still unread
                    if (!r_out_valid || i_ready) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

`default_nettype wire

@@ src/wpsg_datapath.sv @@
// Phase accumulator, table interpolation, shared multiplier and two-lane restoring divider.
`default_nettype none

module wpsg_datapath (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire wpsg_pkg::t_cmd                       i_cmd,
    input  wire logic                                 i_cfg_we,
    input  wire logic [wpsg_pkg::RATE_W-1:0]          i_cfg_data,
    input  wire logic signed [wpsg_pkg::DIST_W-1:0]   i_step_distance,
    input  wire logic                                 i_reversed,
    output logic signed [wpsg_pkg::OUT_W-1:0]         o_cosine,
    output logic signed [wpsg_pkg::OUT_W-1:0]         o_sine
);
    import wpsg_pkg::*;

    logic [RATE_W-1:0]        r_tpm;
    logic [PHASE_BITS-1:0]    r_phase;
    logic [DIST_W-1:0]        r_dist;
    logic                     r_rev;
    logic [PRD_W-1:0]         r_prod;

    logic signed [PT_W-1:0]   r_pt_c;
    logic signed [PT_W-1:0]   r_pt_s;
    logic                     r_dc_neg;
    logic                     r_ds_neg;
    logic [MUL_W-1:0]         r_dc_mag;
    logic [MUL_W-1:0]         r_ds_mag;
    logic [PHASE_BITS-1:0]    r_frac;

    logic                     r_c_neg;
    logic                     r_s_neg;
    logic [MUL_W-1:0]         r_c_mag;
    logic [MUL_W-1:0]         r_s_mag;
    logic [PRD_W-1:0]         r_sq;
    logic [NORM_W-1:0]        r_norm;

    logic [DIV_W-1:0]         r_rem_c;
    logic [DIV_W-1:0]         r_rem_s;
    logic [DIV_W-1:0]         r_dsh;
    logic [Q_W-1:0]           r_q_c;
    logic [Q_W-1:0]           r_q_s;

    logic signed [OUT_W-1:0]  r_cos;
    logic signed [OUT_W-1:0]  r_sin;

    logic [DIST_W-1:0]        w_dist_mag;
    logic [ADV_W-1:0]         w_adv;
    logic [PHASE_BITS-1:0]    w_delta;
    logic [MUL_W-1:0]         w_mul_a;
    logic [MUL_W-1:0]         w_mul_b;
    logic [SEG_BITS:0]        w_seg0;
    logic [SEG_BITS:0]        w_seg1;
    logic signed [DIF_W-1:0]  w_dc;
    logic signed [DIF_W-1:0]  w_ds;
    logic [PRD_W-1:0]         w_rnd_sum;
    logic [RND_W-1:0]         w_rnd;
    logic                     w_i_neg;
    logic signed [PT_W-1:0]   w_i_pt;
    logic signed [VAL_W-1:0]  w_term;
    logic signed [VAL_W-1:0]  w_val;
    logic [VAL_W-1:0]         w_val_mag;
    logic [PRD_W:0]           w_sq_sum;
    logic [NORM_W-1:0]        w_norm;
    logic [DIV_W-1:0]         w_num_c;
    logic [DIV_W-1:0]         w_num_s;
    logic                     w_ge_c;
    logic                     w_ge_s;
    logic [OUT_W-1:0]         w_qc_sat;
    logic [OUT_W-1:0]         w_qs_sat;

    assign w_dist_mag = r_dist[DIST_W-1] ? (~r_dist + 1'b1) : r_dist;

    // rounded advance; only the low phase bits survive, so modular arithmetic suffices
    assign w_adv = (r_dist[DIST_W-1] ? (~r_prod[ADV_W-1:0] + 1'b1) : r_prod[ADV_W-1:0])
                   + (ADV_W'(1) << (ADV_SHIFT - 1));
    assign w_delta = w_adv[ADV_SHIFT +: PHASE_BITS];

    always_comb begin
        unique case (i_cmd.mul_sel)
            MS_ADV: begin
                w_mul_a = MUL_W'(r_tpm);
                w_mul_b = MUL_W'(w_dist_mag);
            end
            MS_DCOS: begin
                w_mul_a = r_dc_mag;
                w_mul_b = MUL_W'(r_frac);
            end
            MS_DSIN: begin
                w_mul_a = r_ds_mag;
                w_mul_b = MUL_W'(r_frac);
            end
            MS_CSQ: begin
                w_mul_a = r_c_mag;
                w_mul_b = r_c_mag;
            end
            MS_SSQ: begin
                w_mul_a = r_s_mag;
                w_mul_b = r_s_mag;
            end
            default: begin
                w_mul_a = '0;
                w_mul_b = '0;
            end
        endcase
    end

    assign w_seg0 = {1'b0, r_phase[PHASE_BITS-1 -: SEG_BITS]};
    assign w_seg1 = w_seg0 + 1'b1;
    assign w_dc   = DIF_W'($signed(COS_PTS[w_seg1])) - DIF_W'($signed(COS_PTS[w_seg0]));
    assign w_ds   = DIF_W'($signed(SIN_PTS[w_seg1])) - DIF_W'($signed(SIN_PTS[w_seg0]));

    // interpolation term, rounded half away from zero on the magnitude
    assign w_rnd_sum = r_prod + (PRD_W'(1) << (PHASE_BITS - 1));
    assign w_rnd     = w_rnd_sum[PHASE_BITS +: RND_W];
    assign w_i_neg   = i_cmd.ld_s ? r_ds_neg : r_dc_neg;
    assign w_i_pt    = i_cmd.ld_s ? r_pt_s : r_pt_c;
    assign w_term    = w_i_neg ? -$signed(VAL_W'(w_rnd)) : $signed(VAL_W'(w_rnd));
    assign w_val     = VAL_W'(w_i_pt) + w_term;
    assign w_val_mag = w_val[VAL_W-1] ? VAL_W'(-w_val) : VAL_W'(w_val);

    // r_prod holds s*s here, r_sq holds c*c; the sum stays far inside the norm width
    assign w_sq_sum = {1'b0, r_sq} + {1'b0, r_prod} + (PRD_W'(1) << 30);
    assign w_norm   = NORM_W'(1 << 29) + w_sq_sum[31 +: NORM_W];

    assign w_num_c = DIV_W'({r_c_mag, 15'b0}) + DIV_W'(r_norm);
    assign w_num_s = DIV_W'({r_s_mag, 15'b0}) + DIV_W'(r_norm);
    assign w_ge_c  = (r_rem_c >= r_dsh);
    assign w_ge_s  = (r_rem_s >= r_dsh);

    assign w_qc_sat = (r_q_c > Q_W'(OUT_ONE)) ? OUT_W'(OUT_ONE) : OUT_W'(r_q_c);
    assign w_qs_sat = (r_q_s > Q_W'(OUT_ONE)) ? OUT_W'(OUT_ONE) : OUT_W'(r_q_s);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tpm   <= RATE_RESET;
            r_phase <= '0;
        end else begin
            if (i_cfg_we) begin
                r_tpm <= i_cfg_data;
            end
            if (i_cmd.upd_phase) begin
                r_phase <= r_rev ? (r_phase + w_delta) : (r_phase - w_delta);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= w_mul_a * w_mul_b;
        if (i_cmd.ld_in) begin
            r_dist <= i_step_distance;
            r_rev  <= i_reversed;
        end
        if (i_cmd.ld_pts) begin
            r_pt_c   <= $signed(COS_PTS[w_seg0]);
            r_pt_s   <= $signed(SIN_PTS[w_seg0]);
            r_dc_neg <= w_dc[DIF_W-1];
            r_ds_neg <= w_ds[DIF_W-1];
            r_dc_mag <= w_dc[DIF_W-1] ? MUL_W'(-w_dc) : MUL_W'(w_dc);
            r_ds_mag <= w_ds[DIF_W-1] ? MUL_W'(-w_ds) : MUL_W'(w_ds);
            r_frac   <= {r_phase[FRAC_BITS-1:0], SEG_BITS'(0)};
        end
        if (i_cmd.ld_c) begin
            r_c_neg <= w_val[VAL_W-1];
            r_c_mag <= MUL_W'(w_val_mag);
        end
        if (i_cmd.ld_s) begin
            r_s_neg <= w_val[VAL_W-1];
            r_s_mag <= MUL_W'(w_val_mag);
        end
        if (i_cmd.ld_sq) begin
            r_sq <= r_prod;
        end
        if (i_cmd.ld_norm) begin
            r_norm <= w_norm;
        end
        if (i_cmd.div_init) begin
            r_rem_c <= w_num_c;
            r_rem_s <= w_num_s;
            r_dsh   <= DIV_W'({r_norm, 1'b0}) << (Q_W - 1);
            r_q_c   <= '0;
            r_q_s   <= '0;
        end else if (i_cmd.div_step) begin
            r_rem_c <= w_ge_c ? (r_rem_c - r_dsh) : r_rem_c;
            r_rem_s <= w_ge_s ? (r_rem_s - r_dsh) : r_rem_s;
            r_q_c   <= {r_q_c[Q_W-2:0], w_ge_c};
            r_q_s   <= {r_q_s[Q_W-2:0], w_ge_s};
            r_dsh   <= r_dsh >> 1;
        end
        if (i_cmd.ld_out) begin
            r_cos <= r_c_neg ? -$signed(w_qc_sat) : $signed(w_qc_sat);
            r_sin <= r_s_neg ? -$signed(w_qs_sat) : $signed(w_qs_sat);
        end
    end

    assign o_cosine = r_cos;
    assign o_sine   = r_sin;

endmodule

`default_nettype wire

@@ src/wheel_phase_sincos_generator_unit.sv @@
// Top level of the wheel phase sine/cosine generator: controller plus datapath.
//
// Keeps a wheel's rotation phase as a 24-bit fraction of a turn. Each input
// word (i_step_distance, Q8.16 metres, and i_reversed) moves the phase by
// turns_per_meter times the distance, added when i_reversed is set and
// subtracted otherwise, wrapping modulo one turn. One output word follows
// per input word: interpolated cosine and sine of the new phase, Q1.14,
// renormalized towards the unit circle and saturated to +-16384.
// Channels: input i_valid/o_ready, output o_valid/i_ready, and a config
// write channel i_cfg_valid/o_cfg_ready/i_cfg_data (turns_per_meter, Q4.20),
// always ready; write it only while the block is idle.
// The sequence for each word runs the 17-step restoring divide (both lanes
// sharing one divisor) and the shared 32x32 multiplier, used five times; the
// next input word is accepted only once the sequencer is back in idle.
// A result waiting in the output register does not block the next input
// word; if the receiver stalls, the following result waits in its last
// stage until the register frees, and input is held off meanwhile.
// Reset: phase cleared, turns_per_meter back to 349525, no output valid.
`default_nettype none

module wheel_phase_sincos_generator_unit (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 i_valid,
    output logic                                      o_ready,
    input  wire logic signed [wpsg_pkg::DIST_W-1:0]   i_step_distance,
    input  wire logic                                 i_reversed,
    output logic                                      o_valid,
    input  wire logic                                 i_ready,
    output logic signed [wpsg_pkg::OUT_W-1:0]         o_cosine,
    output logic signed [wpsg_pkg::OUT_W-1:0]         o_sine,
    input  wire logic                                 i_cfg_valid,
    output logic                                      o_cfg_ready,
    input  wire logic [wpsg_pkg::RATE_W-1:0]          i_cfg_data
);
    import wpsg_pkg::*;

    t_cmd w_cmd;

    assign o_cfg_ready = 1'b1;

    wpsg_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_cmd   (w_cmd)
    );

    wpsg_datapath u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .i_cfg_we        (i_cfg_valid),
        .i_cfg_data      (i_cfg_data),
        .i_step_distance (i_step_distance),
        .i_reversed      (i_reversed),
        .o_cosine        (o_cosine),
        .o_sine          (o_sine)
    );

    a_out_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ($signed(o_cosine) <= OUT_ONE && $signed(o_cosine) >= -OUT_ONE &&
                     $signed(o_sine) <= OUT_ONE && $signed(o_sine) >= -OUT_ONE))
        else $error("result word outside +-1.0");

    a_no_instant_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> !$rose(o_valid))
        else $error("result appeared straight after an accepted word");

    a_result_from_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(!o_ready))
        else $error("result raised without a word in progress");

endmodule

`default_nettype wire
